/* design/tpt_pkg.sv */
// Shared widths, constants and types for the TLB page table translator.
`timescale 1ns / 1ps

package tpt_pkg;

   // Field widths of the request, response and control word
   localparam int VA_W     = 16;
   localparam int PAGE_W   = 8;
   localparam int OFFSET_W = 8;
   localparam int FRAME_W  = 8;
   localparam int LIMIT_W  = 5;
   localparam int NFF_W    = 9;

   // TLB limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef logic [PAGE_W-1:0]   page_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [FRAME_W-1:0]  frame_type;

endpackage

/* design/tlb_page_table_translator.sv */
// TLB page table translator: LRU fully associative TLB plus a demand-paged page table.
`timescale 1ns / 1ps

// Translates one 16-bit virtual address (page in bits 15..8, offset in bits 7..0) per
// request word into a physical address frame*256+offset, flagging a TLB hit and a page
// fault. Each word is accepted in S_IDLE, then in S_LOOK all TLB entries are
// compared at once and the page table RAM is read (or written with the next free
// frame on a fault), and in S_DATA the registered RAM data returns and the response
// register is loaded. A further request is taken while a finished response waits in the
// output register, and the block holds in S_DATA only while that register is still full
// and stalled. csr_wr_data sets the number of TLB entries in use before the oldest is
// evicted (0 acts as 1, values above TLB_DEPTH act as TLB_DEPTH); write it only while the
// block is idle. There is no clearing pass after reset: residency is held in flip-flops.
module tlb_page_table_translator #(
   parameter int TLB_DEPTH  = 16,
   parameter int PAGE_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tpt_pkg::VA_W-1:0]      req_virt_addr,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tpt_pkg::VA_W-1:0]      rsp_phys_addr,
   output logic                          rsp_tlb_hit,
   output logic                          rsp_page_fault,
   // control register
   input  logic                          csr_wr_en,
   input  logic [tpt_pkg::LIMIT_W-1:0]   csr_wr_data
);

   localparam int CNT_W  = $clog2(TLB_DEPTH + 1);
   localparam int IDX_W  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
   localparam int CMP_W  = (CNT_W > tpt_pkg::LIMIT_W) ? CNT_W : tpt_pkg::LIMIT_W;
   localparam int PIDX_W = $clog2(PAGE_COUNT);
   localparam int TAB_N  = 1 << tpt_pkg::PAGE_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_DATA = 2'd2;

   // page number to page table index, worked out at elaboration
   function automatic logic [TAB_N*PIDX_W-1:0] build_idx_table();
      logic [TAB_N*PIDX_W-1:0] t;
      t = '0;
      for (int v = 0; v < TAB_N; v++) begin
         t[v*PIDX_W +: PIDX_W] = PIDX_W'(v % PAGE_COUNT);
      end
      return t;
   endfunction

   localparam logic [TAB_N*PIDX_W-1:0] IDX_TABLE = build_idx_table();

   // control state
   logic [1:0]                     state_ff, state_in;
   logic [tpt_pkg::LIMIT_W-1:0]    tlb_limit_ff;
   logic [CNT_W-1:0]               tlb_count_ff, tlb_count_in;
   logic [PAGE_COUNT-1:0]          resident_ff;
   logic [tpt_pkg::NFF_W-1:0]      next_free_ff;
   logic                           rsp_valid_ff;

   // TLB contents and per-word payload
   tpt_pkg::page_type              tlb_pages_ff [TLB_DEPTH];
   tpt_pkg::page_type              tlb_pages_in [TLB_DEPTH];
   tpt_pkg::page_type              tlb_up       [TLB_DEPTH];
   tpt_pkg::page_type              page_ff;
   tpt_pkg::offset_type            offset_ff;
   logic [PIDX_W-1:0]              idx_ff;
   logic                           hit_ff;
   logic                           fault_ff;
   tpt_pkg::frame_type             new_frame_ff;
   logic [tpt_pkg::VA_W-1:0]       rsp_phys_addr_ff;
   logic                           rsp_tlb_hit_ff;
   logic                           rsp_page_fault_ff;

   logic                           req_take;
   logic                           rsp_load;
   logic                           look;
   logic [TLB_DEPTH-1:0]           match;
   logic                           hit;
   logic [IDX_W-1:0]               hit_idx;
   logic [CMP_W-1:0]               limit_ext;
   logic [CMP_W-1:0]               eff_limit;
   logic                           evict;
   logic [CNT_W-1:0]               rem_pos;
   logic [CNT_W-1:0]               last_pos;
   logic                           fault;
   tpt_pkg::frame_type             ram_rd_data;
   tpt_pkg::frame_type             frame;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign look      = (state_ff == S_LOOK);
   assign rsp_load  = (state_ff == S_DATA) && (!rsp_valid_ff || !rsp_stall);

   // neighbour one slot newer, used when entries close up towards the old end
   for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_up
      if (g < TLB_DEPTH - 1) begin : g_mid
         assign tlb_up[g] = tlb_pages_ff[g+1];
      end else begin : g_top
         assign tlb_up[g] = tlb_pages_ff[g];
      end
   end

   // parallel tag compare over the live entries, lowest position wins
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
         match[i] = (CNT_W'(i) < tlb_count_ff) && (tlb_pages_ff[i] == page_ff);
      end
      for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
      hit = |match;
   end

   // clamp the limit to 1..TLB_DEPTH
   always_comb begin
      limit_ext = CMP_W'(tlb_limit_ff);
      if (limit_ext == '0) begin
         eff_limit = CMP_W'(1);
      end else if (limit_ext > CMP_W'(TLB_DEPTH)) begin
         eff_limit = CMP_W'(TLB_DEPTH);
      end else begin
         eff_limit = limit_ext;
      end
      evict = (CMP_W'(tlb_count_ff) >= eff_limit);
   end

   // LRU update: drop one entry (hit position or oldest) then put page at newest end
   always_comb begin
      if (hit) begin
         rem_pos  = CNT_W'(hit_idx);
         last_pos = tlb_count_ff - CNT_W'(1);
      end else if (evict) begin
         rem_pos  = '0;
         last_pos = tlb_count_ff - CNT_W'(1);
      end else begin
         rem_pos  = tlb_count_ff;
         last_pos = tlb_count_ff;
      end
      for (int i = 0; i < TLB_DEPTH; i++) begin
         if (CNT_W'(i) < rem_pos) begin
            tlb_pages_in[i] = tlb_pages_ff[i];
         end else if (CNT_W'(i) < last_pos) begin
            tlb_pages_in[i] = tlb_up[i];
         end else if (CNT_W'(i) == last_pos) begin
            tlb_pages_in[i] = page_ff;
         end else begin
            tlb_pages_in[i] = tlb_pages_ff[i];
         end
      end
      tlb_count_in = last_pos + CNT_W'(1);
   end

   // page not yet resident on a TLB miss: hand out next frame
   assign fault = !hit && !resident_ff[idx_ff];

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tlb_limit_ff <= tpt_pkg::LIMIT_RESET;
         tlb_count_ff <= '0;
         resident_ff  <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            tlb_limit_ff <= csr_wr_data;
         end
         if (look) begin
            tlb_count_ff <= tlb_count_in;
            if (fault) begin
               resident_ff[idx_ff] <= 1'b1;
               next_free_ff        <= next_free_ff + tpt_pkg::NFF_W'(1);
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         page_ff   <= req_virt_addr[tpt_pkg::VA_W-1 -: tpt_pkg::PAGE_W];
         offset_ff <= req_virt_addr[tpt_pkg::OFFSET_W-1:0];
         idx_ff    <= IDX_TABLE[req_virt_addr[tpt_pkg::VA_W-1 -: tpt_pkg::PAGE_W]*PIDX_W +: PIDX_W];
      end
      if (look) begin
         tlb_pages_ff <= tlb_pages_in;
         hit_ff       <= hit;
         fault_ff     <= fault;
         new_frame_ff <= next_free_ff[tpt_pkg::FRAME_W-1:0];
      end
      if (rsp_load) begin
         rsp_phys_addr_ff  <= {frame, offset_ff};
         rsp_tlb_hit_ff    <= hit_ff;
         rsp_page_fault_ff <= fault_ff;
      end
   end

   // page table: frame of each page
   tpt_ram #(
      .WIDTH (tpt_pkg::FRAME_W),
      .DEPTH (PAGE_COUNT)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (look && fault),
      .wr_addr (idx_ff),
      .wr_data (next_free_ff[tpt_pkg::FRAME_W-1:0]),
      .rd_en   (look),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // a fault's frame was just written, so the read returned stale data
   assign frame = fault_ff ? new_frame_ff : ram_rd_data;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_phys_addr  = rsp_phys_addr_ff;
   assign rsp_tlb_hit    = rsp_tlb_hit_ff;
   assign rsp_page_fault = rsp_page_fault_ff;

endmodule

/* design/tpt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module tpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* design/tpt_checker.sv */
// Port-level checks for the TLB page table translator, bound to the top level.
`timescale 1ns / 1ps

module tpt_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [tpt_pkg::VA_W-1:0] rsp_phys_addr,
   input logic                     rsp_tlb_hit,
   input logic                     rsp_page_fault
);

   // no response word straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a TLB hit never assigns a frame
   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("hit and page fault together");

   // one word in flight: after an accept the request side holds off
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted while one is in flight");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_phys_addr)
         && $stable(rsp_tlb_hit) && $stable(rsp_page_fault)))
      else $error("stalled response word changed");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_phys_addr  (rsp_phys_addr),
   .rsp_tlb_hit    (rsp_tlb_hit),
   .rsp_page_fault (rsp_page_fault)
);
